@@ hdl/cexp_pkg.sv @@
// Constants, types and tables of the companding expander.
package cexp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int K_W      = 16;
    localparam int PEAK_W   = 15;
    localparam int Y_W      = FRAC_W + 1;
    localparam int LNV_W    = 20;
    localparam int T_W      = 19;
    localparam int U_W      = 20;
    localparam int IP_W     = 4;
    localparam int TERM_W   = FRAC_W + 1;
    localparam int SUM_W    = FRAC_W + 2;
    localparam int X_W      = 29;
    localparam int PX_W     = PEAK_W + X_W;
    localparam int TAYLOR_TERMS = 24;
    localparam int RECIP_W      = 23;
    localparam int RECIP_SHIFT  = 22;

    localparam logic [K_W-1:0]    K_ONE    = 16'd256;
    localparam logic [T_W-1:0]    T_ONE    = 19'h10000;
    localparam logic [Y_W-1:0]    Y_ONE    = 17'h10000;
    localparam logic [15:0]       LN2_Q    = 16'd45426;
    localparam logic [16:0]       INVLN2_Q = 17'd94548;

    // Register indexes (word address bits)
    localparam logic [1:0] REG_LAW_MODE   = 2'd0;
    localparam logic [1:0] REG_LAW_K      = 2'd1;
    localparam logic [1:0] REG_PEAK_LEVEL = 2'd2;

    // ceil(2^22 / n): exact floor division by n for 17-bit dividends
    localparam logic [RECIP_W-1:0] TAYLOR_RECIP [1:TAYLOR_TERMS] = '{
        23'd4194304, 23'd2097152, 23'd1398102, 23'd1048576, 23'd838861, 23'd699051,
        23'd599187,  23'd524288,  23'd466034,  23'd419431,  23'd381301, 23'd349526,
        23'd322639,  23'd299594,  23'd279621,  23'd262144,  23'd246724, 23'd233017,
        23'd220753,  23'd209716,  23'd199729,  23'd190651,  23'd182362, 23'd174763
    };

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_LOAD,
        LN_SQUARE,
        LN_SCALE
    } ln_state_t;

    typedef struct packed {
        logic        vld;
        logic        neg;
        logic        sat;
        logic        lsb;
        logic [14:0] rem;
        logic [16:0] quo;
    } dvy_t;

    typedef struct packed {
        logic           vld;
        logic           neg;
        logic [T_W-1:0] t;
    } tstage_t;

    typedef struct packed {
        logic           vld;
        logic           neg;
        logic           lin;
        logic [15:0]    tlin;
        logic [U_W-1:0] u;
    } ustage_t;

    typedef struct packed {
        logic              vld;
        logic              neg;
        logic              lin;
        logic [15:0]       tlin;
        logic [15:0]       z;
        logic [IP_W-1:0]   ip;
        logic [TERM_W-1:0] term;
        logic [SUM_W-1:0]  sum;
    } tay_t;

    typedef struct packed {
        logic           vld;
        logic           neg;
        logic [X_W-1:0] x;
    } xstage_t;

    typedef struct packed {
        logic            vld;
        logic            neg;
        logic [PX_W-1:0] px;
    } pstage_t;

    typedef struct packed {
        logic        vld;
        logic        neg;
        logic        sat;
        logic [15:0] rem;
        logic [15:0] nlow;
        logic [15:0] quo;
    } dvo_t;

endpackage

@@ hdl/companding_expander_top.sv @@
// Continuous mu-law / A-law expander: register file, log unit and sample pipeline.
// Throughput: one sample per cycle while the log unit is idle; the whole pipeline holds while the result waits.
// After reset, and after every write of law_mode or law_k, the shared log unit runs
// through its steps (load, one squaring per fraction bit, scale) and s_ready stays low meanwhile.
// Reset: synchronous, active low; registers go to mu-law, K = 1.0, peak level 1.
module companding_expander_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_in,
    // expanded results
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample_out
);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic                        law_mode_reg;
    logic [cexp_pkg::K_W-1:0]    law_k_reg;
    logic [cexp_pkg::PEAK_W-1:0] peak_level_reg;
    logic                        cfg_wr;
    logic [1:0]                  cfg_idx;
    logic [cexp_pkg::K_W-1:0]    k_eff;
    logic [cexp_pkg::PEAK_W-1:0] p_eff;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            law_mode_reg   <= 1'b0;
            law_k_reg      <= cexp_pkg::K_ONE;
            peak_level_reg <= 15'd1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                cexp_pkg::REG_LAW_MODE:   law_mode_reg   <= pwdata[0];
                cexp_pkg::REG_LAW_K:      law_k_reg      <= pwdata[15:0];
                cexp_pkg::REG_PEAK_LEVEL: peak_level_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            cexp_pkg::REG_LAW_MODE:   prdata = {31'd0, law_mode_reg};
            cexp_pkg::REG_LAW_K:      prdata = {16'd0, law_k_reg};
            cexp_pkg::REG_PEAK_LEVEL: prdata = {17'd0, peak_level_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // K below one acts as one; a zero peak acts as one
    assign k_eff = (law_k_reg < cexp_pkg::K_ONE) ? cexp_pkg::K_ONE : law_k_reg;
    assign p_eff = (peak_level_reg == '0) ? 15'd1 : peak_level_reg;

    // ------------------------------------------------------------------
    // Log unit: ln(1+K) for mu-law, 1+ln(K) for A-law, held in lnv_reg.
    // log2 fraction by repeated squaring, one bit per cycle.
    // ------------------------------------------------------------------
    cexp_pkg::ln_state_t ln_state_reg, ln_state_next;
    logic [3:0]  ln_cnt_reg, ln_cnt_next;
    logic [16:0] ln_x_reg, ln_x_next;
    logic [4:0]  ln_n_reg, ln_n_next;
    logic [15:0] ln_frac_reg, ln_frac_next;
    logic [cexp_pkg::LNV_W-1:0] lnv_reg, lnv_next;
    logic [16:0] ln_arg;
    logic [4:0]  ln_lead;
    logic [33:0] ln_sq;
    logic [17:0] ln_sq_hi;
    logic [3:0]  ln_ipart;
    logic [19:0] ln_lg;
    logic [35:0] ln_scale;
    logic [19:0] ln_val;
    logic        ln_busy;

    assign ln_arg   = law_mode_reg ? {1'b0, k_eff} : ({1'b0, k_eff} + 17'd256);
    assign ln_sq    = ln_x_reg * ln_x_reg;
    assign ln_sq_hi = ln_sq[33:16];
    assign ln_ipart = 4'(ln_n_reg - 5'd8);
    assign ln_lg    = {ln_ipart, ln_frac_reg};
    assign ln_scale = ln_lg * cexp_pkg::LN2_Q;
    assign ln_val   = ln_scale[35:16];
    assign ln_busy  = (ln_state_reg != cexp_pkg::LN_IDLE);

    always_comb begin
        ln_lead = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (ln_arg[i]) ln_lead = 5'(i);
        end
    end

    always_comb begin
        ln_state_next = ln_state_reg;
        ln_cnt_next   = ln_cnt_reg;
        ln_x_next     = ln_x_reg;
        ln_n_next     = ln_n_reg;
        ln_frac_next  = ln_frac_reg;
        lnv_next      = lnv_reg;
        case (ln_state_reg)
            cexp_pkg::LN_IDLE: ;
            cexp_pkg::LN_LOAD: begin
                ln_x_next     = 17'(ln_arg << (5'd16 - ln_lead));
                ln_n_next     = ln_lead;
                ln_frac_next  = '0;
                ln_cnt_next   = '0;
                ln_state_next = cexp_pkg::LN_SQUARE;
            end
            cexp_pkg::LN_SQUARE: begin
                if (ln_sq_hi[17]) begin
                    ln_x_next = ln_sq_hi[17:1];
                    ln_frac_next[4'd15 - ln_cnt_reg] = 1'b1;
                end else begin
                    ln_x_next = ln_sq_hi[16:0];
                end
                ln_cnt_next = ln_cnt_reg + 4'd1;
                if (ln_cnt_reg == 4'd15) ln_state_next = cexp_pkg::LN_SCALE;
            end
            cexp_pkg::LN_SCALE: begin
                lnv_next      = law_mode_reg ? (ln_val + 20'h10000) : ln_val;
                ln_state_next = cexp_pkg::LN_IDLE;
            end
            default: ln_state_next = cexp_pkg::LN_IDLE;
        endcase
        // recompute whenever the law or K changes
        if (cfg_wr && (cfg_idx == cexp_pkg::REG_LAW_MODE || cfg_idx == cexp_pkg::REG_LAW_K))
            ln_state_next = cexp_pkg::LN_LOAD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ln_state_reg <= cexp_pkg::LN_LOAD;
        end else begin
            ln_state_reg <= ln_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        ln_cnt_reg  <= ln_cnt_next;
        ln_x_reg    <= ln_x_next;
        ln_n_reg    <= ln_n_next;
        ln_frac_reg <= ln_frac_next;
        lnv_reg     <= lnv_next;
    end

    // ------------------------------------------------------------------
    // Sample pipeline. Every stage advances together; hold all of them
    // while a finished result waits on m_ready.
    // ------------------------------------------------------------------
    logic adv;
    logic m_valid_reg, m_valid_next;
    logic [15:0] m_sample_out_reg, m_sample_out_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && !ln_busy;

    // Stage 0: magnitude, sign, clamp detect (|s| >= 2P means y of 2.0 or more)
    cexp_pkg::dvy_t dvy_reg  [0:17];
    cexp_pkg::dvy_t dvy_next [0:17];
    logic [16:0] in_ext;
    logic [16:0] in_mag;

    assign in_ext = {s_sample_in[15], s_sample_in};
    assign in_mag = in_ext[16] ? (17'd0 - in_ext) : in_ext;

    always_comb begin
        dvy_next[0].vld = s_valid && s_ready;
        dvy_next[0].neg = in_ext[16];
        dvy_next[0].sat = (in_mag >= {1'b0, p_eff, 1'b0});
        dvy_next[0].lsb = in_mag[0];
        dvy_next[0].rem = in_mag[15:1];
        dvy_next[0].quo = '0;
    end

    // Stages 1..17: restoring division |s|*2^16 / P, one quotient bit each
    for (genvar i = 1; i <= 17; i++) begin : g_div_y
        logic [15:0] sh;
        logic        ge;
        logic        bit_in;
        assign bit_in = (i == 1) ? dvy_reg[i-1].lsb : 1'b0;
        assign sh     = {dvy_reg[i-1].rem, bit_in};
        assign ge     = (sh >= {1'b0, p_eff});
        always_comb begin
            dvy_next[i]     = dvy_reg[i-1];
            dvy_next[i].rem = ge ? 15'(sh - {1'b0, p_eff}) : sh[14:0];
            dvy_next[i].quo = {dvy_reg[i-1].quo[15:0], ge};
        end
    end

    for (genvar i = 0; i <= 17; i++) begin : g_dvy_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvy_reg[i].vld <= 1'b0;
            end else if (adv) begin
                dvy_reg[i] <= dvy_next[i];
            end
        end
    end

    // Stage T: clamp y to 1.0, t = y * lnv
    cexp_pkg::tstage_t ts_reg, ts_next;
    logic [cexp_pkg::Y_W-1:0] y_val;
    logic [36:0] ty_prod;

    assign y_val   = (dvy_reg[17].sat || dvy_reg[17].quo > cexp_pkg::Y_ONE)
                     ? cexp_pkg::Y_ONE : dvy_reg[17].quo;
    assign ty_prod = y_val * lnv_reg;

    always_comb begin
        ts_next.vld = dvy_reg[17].vld;
        ts_next.neg = dvy_reg[17].neg;
        ts_next.t   = ty_prod[34:16];
    end

    // Stage U: pick the exponent argument, u = arg / ln2
    cexp_pkg::ustage_t us_reg, us_next;
    logic [cexp_pkg::T_W-1:0] e_arg;
    logic [35:0] u_prod;

    assign e_arg  = law_mode_reg ? (ts_reg.t - cexp_pkg::T_ONE) : ts_reg.t;
    assign u_prod = e_arg * cexp_pkg::INVLN2_Q;

    always_comb begin
        us_next.vld  = ts_reg.vld;
        us_next.neg  = ts_reg.neg;
        us_next.lin  = law_mode_reg && (ts_reg.t < cexp_pkg::T_ONE);
        us_next.tlin = ts_reg.t[15:0];
        us_next.u    = u_prod[35:16];
    end

    // Stage Z: split u, z = frac(u) * ln2, seed the series
    cexp_pkg::tay_t tay_reg  [0:2*cexp_pkg::TAYLOR_TERMS];
    cexp_pkg::tay_t tay_next [0:2*cexp_pkg::TAYLOR_TERMS];
    logic [31:0] z_prod;

    assign z_prod = us_reg.u[15:0] * cexp_pkg::LN2_Q;

    always_comb begin
        tay_next[0].vld  = us_reg.vld;
        tay_next[0].neg  = us_reg.neg;
        tay_next[0].lin  = us_reg.lin;
        tay_next[0].tlin = us_reg.tlin;
        tay_next[0].z    = z_prod[31:16];
        tay_next[0].ip   = us_reg.u[19:16];
        tay_next[0].term = cexp_pkg::Y_ONE;
        tay_next[0].sum  = {1'b0, cexp_pkg::Y_ONE};
    end

    // Taylor terms: multiply by z, then divide by the term index
    for (genvar j = 1; j <= cexp_pkg::TAYLOR_TERMS; j++) begin : g_taylor
        logic [32:0] mz;
        logic [39:0] md;
        assign mz = tay_reg[2*j-2].term * tay_reg[2*j-2].z;
        assign md = tay_reg[2*j-1].term * cexp_pkg::TAYLOR_RECIP[j];
        always_comb begin
            tay_next[2*j-1]      = tay_reg[2*j-2];
            tay_next[2*j-1].term = mz[32:16];
            tay_next[2*j]        = tay_reg[2*j-1];
            tay_next[2*j].term   = md[38:22];
            tay_next[2*j].sum    = tay_reg[2*j-1].sum + {1'b0, md[38:22]};
        end
    end

    for (genvar i = 0; i <= 2*cexp_pkg::TAYLOR_TERMS; i++) begin : g_tay_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tay_reg[i].vld <= 1'b0;
            end else if (adv) begin
                tay_reg[i] <= tay_next[i];
            end
        end
    end

    // Stage X: scale by 2^ip and form the expanded value per law
    cexp_pkg::xstage_t xs_reg, xs_next;
    localparam int TL = 2*cexp_pkg::TAYLOR_TERMS;
    logic [cexp_pkg::X_W-1:0] expo;

    assign expo = cexp_pkg::X_W'(tay_reg[TL].sum) << tay_reg[TL].ip;

    always_comb begin
        xs_next.vld = tay_reg[TL].vld;
        xs_next.neg = tay_reg[TL].neg;
        if (law_mode_reg) begin
            xs_next.x = tay_reg[TL].lin ? cexp_pkg::X_W'(tay_reg[TL].tlin) : expo;
        end else begin
            xs_next.x = (expo > cexp_pkg::X_W'(cexp_pkg::Y_ONE))
                        ? (expo - cexp_pkg::X_W'(cexp_pkg::Y_ONE)) : '0;
        end
    end

    // Stage P: P * X
    cexp_pkg::pstage_t ps_reg, ps_next;

    always_comb begin
        ps_next.vld = xs_reg.vld;
        ps_next.neg = xs_reg.neg;
        ps_next.px  = p_eff * xs_reg.x;
    end

    // Stage N: add half a divisor, drop 16 bits, detect quotient overflow
    cexp_pkg::dvo_t dvo_reg  [0:16];
    cexp_pkg::dvo_t dvo_next [0:16];
    logic [52:0] n_sum;
    logic [36:0] n_val;

    assign n_sum = {1'b0, ps_reg.px, 8'd0} + (53'(k_eff) << 15);
    assign n_val = n_sum[52:16];

    always_comb begin
        dvo_next[0].vld  = ps_reg.vld;
        dvo_next[0].neg  = ps_reg.neg;
        dvo_next[0].sat  = (n_val[36:16] >= 21'(k_eff));
        dvo_next[0].rem  = n_val[31:16];
        dvo_next[0].nlow = n_val[15:0];
        dvo_next[0].quo  = '0;
    end

    // Stages 1..16: restoring division by K, one quotient bit each
    for (genvar i = 1; i <= 16; i++) begin : g_div_k
        logic [16:0] sh;
        logic        ge;
        assign sh = {dvo_reg[i-1].rem, dvo_reg[i-1].nlow[15]};
        assign ge = (sh >= {1'b0, k_eff});
        always_comb begin
            dvo_next[i]      = dvo_reg[i-1];
            dvo_next[i].rem  = ge ? 16'(sh - {1'b0, k_eff}) : sh[15:0];
            dvo_next[i].nlow = {dvo_reg[i-1].nlow[14:0], 1'b0};
            dvo_next[i].quo  = {dvo_reg[i-1].quo[14:0], ge};
        end
    end

    for (genvar i = 0; i <= 16; i++) begin : g_dvo_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvo_reg[i].vld <= 1'b0;
            end else if (adv) begin
                dvo_reg[i] <= dvo_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg.vld <= 1'b0;
            us_reg.vld <= 1'b0;
            xs_reg.vld <= 1'b0;
            ps_reg.vld <= 1'b0;
        end else if (adv) begin
            ts_reg <= ts_next;
            us_reg <= us_next;
            xs_reg <= xs_next;
            ps_reg <= ps_next;
        end
    end

    // Output: saturate, apply sign
    logic [15:0] res_cap;
    logic [15:0] res_mag;

    assign res_cap = dvo_reg[16].neg ? 16'h8000 : 16'h7fff;
    assign res_mag = (dvo_reg[16].sat || dvo_reg[16].quo > res_cap) ? res_cap : dvo_reg[16].quo;

    always_comb begin
        m_valid_next      = dvo_reg[16].vld;
        m_sample_out_next = dvo_reg[16].neg ? (16'd0 - res_mag) : res_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_sample_out_reg <= m_sample_out_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

endmodule

@@ tb/tb_companding_expander_top.sv @@
// Self-checking testbench of the continuous mu-law / A-law expander.
`timescale 1ns / 1ps

module tb_companding_expander_top;

    typedef longint unsigned u64;

    // Q.16 constants, rounded from their Q.32 forms
    localparam u64 LN2_Q16    = (64'd2977044472 + 64'd32768) >> 16;
    localparam u64 INVLN2_Q16 = (64'd6196328019 + 64'd32768) >> 16;
    localparam u64 ONE_Q16    = 64'd1 << 16;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_sample_out;

    companding_expander_top dut (.*);

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the register file, updated on every write
    logic        law_mode_sh   = 1'b0;
    logic [15:0] law_k_sh      = cexp_pkg::K_ONE;
    logic [14:0] peak_level_sh = 15'd1;

    // Expected expanded samples, oldest first
    logic signed [15:0] expanded_q[$];
    int mismatches = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int cycles = 0;

    // ln(m / 256) in Q.16, m >= 256
    function automatic u64 ln_q16(u64 m);
        int n;
        u64 x, frac, lg;
        n = 0;
        frac = 0;
        while (n < 62 && (m >> (n + 1)) != 0)
            n++;
        x = (m << 16) >> n;
        for (int i = 1; i <= 16; i++) begin
            x = (x * x) >> 16;
            if (x >= (ONE_Q16 << 1)) begin
                x = x >> 1;
                frac |= u64'(1) << (16 - i);
            end
        end
        lg = (n > 8) ? (u64'(n - 8) << 16) : 0;
        lg |= frac;
        return (lg * LN2_Q16) >> 16;
    endfunction

    // exp(t) in Q.16 via 2^u, fraction by Taylor series
    function automatic u64 exp_q16(u64 t);
        u64 u, ip, z, sum, term;
        u = (t * INVLN2_Q16) >> 16;
        ip = u >> 16;
        z = ((u & (ONE_Q16 - 1)) * LN2_Q16) >> 16;
        sum = ONE_Q16;
        term = ONE_Q16;
        for (int k = 1; k <= cexp_pkg::TAYLOR_TERMS; k++) begin
            term = ((term * z) >> 16) / u64'(k);
            sum += term;
        end
        if (ip > 24)
            ip = 24;
        return sum << ip;
    endfunction

    // Expand one sample with the current shadow registers
    function automatic logic signed [15:0] expand_sample(logic signed [15:0] s);
        bit neg;
        u64 mag, p, k, y, x, t, lnv, num, den, res, cap;
        neg = s[15];
        mag = neg ? (u64'(65536) - u64'(s[15:0])) : u64'(s[15:0]);
        p = (peak_level_sh != 0) ? u64'(peak_level_sh) : 1;
        k = (law_k_sh < cexp_pkg::K_ONE) ? u64'(cexp_pkg::K_ONE) : u64'(law_k_sh);
        y = (mag << 16) / p;
        if (y > ONE_Q16)
            y = ONE_Q16;
        if (!law_mode_sh) begin
            lnv = ln_q16(k + 256);
            t = (y * lnv) >> 16;
            x = exp_q16(t);
            x = (x > ONE_Q16) ? x - ONE_Q16 : 0;
        end else begin
            lnv = ONE_Q16 + ln_q16(k);
            t = (y * lnv) >> 16;
            x = (t < ONE_Q16) ? t : exp_q16(t - ONE_Q16);
        end
        num = (p * x) << 8;
        den = k << 16;
        res = (num + (den >> 1)) / den;
        cap = neg ? 64'd32768 : 64'd32767;
        if (res > cap)
            res = cap;
        return neg ? 16'(u64'(65536) - res) : 16'(res);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    int hold_left = 0;
    bit hold_taken = 1'b0;
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expanded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result sample_out=%0d", m_sample_out);
            end else begin
                logic signed [15:0] want;
                want = expanded_q.pop_front();
                if (want !== m_sample_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample_out mismatch: expected %0d, got %0d",
                                 want, m_sample_out);
                end
            end
        end
    end

    // Hard stop on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request; record its expectation at the accepting edge.
    // typed: take the expected value from want instead of the predictor.
    task automatic send_sample(logic signed [15:0] s, bit typed, logic signed [15:0] want);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_in <= s;
        do
            @(posedge aclk);
        while (!s_ready);
        expanded_q.push_back(typed ? want : expand_sample(s));
    endtask

    // Hold until every result is back and the pipeline is empty
    task automatic drain();
        s_valid <= 1'b0;
        while (expanded_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write in a setup and an access phase; the block must be idle
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cexp_pkg::REG_LAW_MODE:   law_mode_sh = val[0];
            cexp_pkg::REG_LAW_K:      law_k_sh = val[15:0];
            cexp_pkg::REG_PEAK_LEVEL: peak_level_sh = val[14:0];
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] random_sample();
        int p, sel, r;
        p = (peak_level_sh != 0) ? int'(peak_level_sh) : 1;
        sel = $urandom_range(99);
        if (sel < 40)
            return 16'($urandom);
        if (sel < 70)
            r = $urandom_range(p + 1);
        else if (sel < 90)
            r = $urandom_range(p / 16 + 1);
        else
            return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        return $urandom_range(1) ? 16'(-r) : 16'(r);
    endfunction

    function automatic logic [15:0] random_k();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd255;
            2: return cexp_pkg::K_ONE;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] random_peak();
        case ($urandom_range(5))
            0: return 15'd0;
            1: return 15'd1;
            2: return 15'h7fff;
            3: return 15'($urandom_range(64));
            default: return 15'($urandom);
        endcase
    endfunction

    // Directed rows: either a register write or a sample
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] val;
        logic signed [15:0] s;
        bit          typed;
        logic signed [15:0] want;
    } row_t;

    row_t rows[] = '{
        // reset setting: zero sample gives zero
        '{0, 0, 0, 16'sd0, 1, 16'sd0},
        '{0, 0, 0, 16'sd32767, 0, 0},
        '{0, 0, 0, -16'sd32768, 0, 0},
        '{0, 0, 0, 16'sd1, 0, 0},
        '{0, 0, 0, -16'sd1, 0, 0},
        // full-scale peak, largest K, mu-law
        '{1, cexp_pkg::REG_PEAK_LEVEL, 32'd32767, 0, 0, 0},
        '{1, cexp_pkg::REG_LAW_K, 32'hffff, 0, 0, 0},
        '{0, 0, 0, 16'sd32767, 0, 0},
        '{0, 0, 0, -16'sd32768, 0, 0},
        '{0, 0, 0, 16'sd16384, 0, 0},
        '{0, 0, 0, -16'sd100, 0, 0},
        '{0, 0, 0, 16'sd0, 1, 16'sd0},
        // A-law, both the linear and exponential segments
        '{1, cexp_pkg::REG_LAW_MODE, 32'd1, 0, 0, 0},
        '{0, 0, 0, 16'sd32767, 0, 0},
        '{0, 0, 0, -16'sd32767, 0, 0},
        '{0, 0, 0, 16'sd200, 0, 0},
        '{0, 0, 0, -16'sd5, 0, 0},
        '{0, 0, 0, 16'sd0, 1, 16'sd0},
        // K below one acts as one
        '{1, cexp_pkg::REG_LAW_K, 32'd0, 0, 0, 0},
        '{0, 0, 0, 16'sd12345, 0, 0},
        '{0, 0, 0, -16'sd32768, 0, 0},
        // zero peak acts as one
        '{1, cexp_pkg::REG_PEAK_LEVEL, 32'd0, 0, 0, 0},
        '{0, 0, 0, 16'sd1, 0, 0},
        '{0, 0, 0, -16'sd1, 0, 0},
        '{0, 0, 0, 16'sd0, 1, 16'sd0},
        '{1, cexp_pkg::REG_LAW_MODE, 32'd0, 0, 0, 0},
        '{1, cexp_pkg::REG_LAW_K, 32'd100, 0, 0, 0},
        '{0, 0, 0, 16'sd7, 0, 0},
        '{0, 0, 0, -16'sd9, 0, 0},
        '{0, 0, 0, 16'sd32767, 0, 0}
    };

    initial begin
        int n_items;
        // hold the synchronous reset, then release it
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                drain();
                reg_write(rows[i].idx, rows[i].val);
            end else begin
                send_sample(rows[i].s, rows[i].typed, rows[i].want);
            end
        end

        // Random phases; each one picks a setting and an idling mix
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            reg_write(cexp_pkg::REG_LAW_MODE, 32'($urandom_range(1)));
            reg_write(cexp_pkg::REG_LAW_K, 32'(random_k()));
            reg_write(cexp_pkg::REG_PEAK_LEVEL, 32'(random_peak()));
            case (ph % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin sender_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            // long receiver hold-off while requests keep coming: fill the pipeline
            if (ph == 4)
                hold_req = 1'b1;
            n_items = 140 + $urandom_range(10);
            repeat (n_items) send_sample(random_sample(), 1'b0, 16'sd0);
        end
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/cexp_pkg.sv
hdl/companding_expander_top.sv
tb/tb_companding_expander_top.sv
